// File: hdl/engine_idle_throttle_controller_macros.svh
`ifndef ENGINE_IDLE_THROTTLE_CONTROLLER_MACROS_SVH
`define ENGINE_IDLE_THROTTLE_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define EITC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eitc check failed");

// next-cycle implication
`define EITC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eitc check failed");

`endif

// File: hdl/eitc_pkg.sv
package eitc_pkg;

    localparam int SIGNAL_MAX     = 1000;
    localparam int SIGNAL_NEUTRAL = 0;

    localparam int RPM_W    = 16;
    localparam int SIG_W    = 11;
    localparam int STEP_W   = 10;
    localparam int TIME_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 32;

    // warm-up factor in Q0.16, 1.0 needs the extra bit
    localparam int FIX_W = 17;
    localparam logic [FIX_W-1:0] FIX_ONE = FIX_W'(65536);

    localparam int OPND_W = 18;
    localparam int PROD_W = 2 * OPND_W;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int FAST_MS = 20;
    localparam int SLOW_MS = 400;

    // held throttle arithmetic is done two bits wider to see the clamps
    localparam int THR_W = SIG_W + 2;
    localparam logic signed [THR_W-1:0] THR_HI = THR_W'(SIGNAL_MAX / 2);
    localparam logic signed [THR_W-1:0] THR_LO = THR_W'(SIGNAL_NEUTRAL);
    localparam logic [SIG_W-1:0] HELD_RESET = SIG_W'(SIGNAL_MAX / 4);

    localparam logic [RPM_W-1:0]  RPM_START_RESET   = RPM_W'(1100);
    localparam logic [RPM_W-1:0]  RPM_RUNNING_RESET = RPM_W'(900);
    localparam logic [SIG_W-1:0]  LOAD_START_RESET  = SIG_W'(5);
    localparam logic [TIME_W-1:0] WARMUP_RESET      = TIME_W'(10);
    localparam logic [STEP_W-1:0] STEP_RESET        = STEP_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RPM_START   = 3'd0,
        CFG_RPM_RUNNING = 3'd1,
        CFG_LOAD_START  = 3'd2,
        CFG_WARMUP_TIME = 3'd3,
        CFG_THR_STEP    = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        MUL_TARGET,
        MUL_LOAD,
        MUL_NUM,
        MUL_FAST,
        MUL_SLOW
    } mul_op_t;

    typedef struct packed {
        logic signed [FIX_W-1:0] ramp_diff;
        logic [FIX_W-1:0]        fct;
        logic signed [SIG_W-1:0] load_start;
        logic signed [FIX_W-1:0] gap;
        logic [RPM_W-1:0]        delta;
        logic [RPM_W-1:0]        den_abs;
    } mul_src_t;

endpackage

// File: hdl/eitc_div.sv
module eitc_div
    import eitc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [TIME_W-1:0]         dividend,
    input  logic [TIME_W-1:0]         divisor,
    output logic                      done_reg,
    output logic [DIV_STEPS-1:0]      quo_reg
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [TIME_W:0]      shifted;
    logic                 fits;

    // dividend is elapsed << 16, low bits shift in as zero
    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? TIME_W'(shifted - {1'b0, divisor}) : shifted[TIME_W-1:0];
            quo_reg <= {quo_reg[DIV_STEPS-2:0], fits};
        end
    end

endmodule

// File: hdl/eitc_mul.sv
module eitc_mul
    import eitc_pkg::*;
(
    input  logic                     clk,
    input  mul_op_t                  op,
    input  mul_src_t                 src,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic signed [OPND_W-1:0] opa;
    logic signed [OPND_W-1:0] opb;

    always_comb
    begin
        case (op)
            MUL_TARGET:
            begin
                opa = {src.ramp_diff[FIX_W-1], src.ramp_diff};
                opb = {1'b0, src.fct};
            end
            MUL_LOAD:
            begin
                opa = {{(OPND_W-SIG_W){src.load_start[SIG_W-1]}}, src.load_start};
                opb = {1'b0, FIX_W'(FIX_ONE - src.fct)};
            end
            MUL_NUM:
            begin
                opa = {src.gap[FIX_W-1], src.gap};
                opb = {2'b00, src.delta};
            end
            MUL_FAST:
            begin
                opa = {2'b00, src.den_abs};
                opb = OPND_W'(FAST_MS);
            end
            MUL_SLOW:
            begin
                opa = {2'b00, src.den_abs};
                opb = OPND_W'(SLOW_MS);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
    end

endmodule

// File: hdl/engine_idle_throttle_controller.sv
// Idle throttle controller. A control tick (func 0) skips the divider once elapsed time has
// reached warmup_time (or warmup_time is 0); while warm-up is still running, a 16-step
// restoring divider forms the warm-up factor first. The rest is five passes through one shared
// 18x18 multiplier for the rpm target, the load, the time-to-target numerator and the 20 ms and
// 400 ms bounds, then a decision step and the output step.
// in_ready rises together with out_valid, so a new tick is taken only once the last one is through.
// A restart item (func 1) is taken without leaving the idle state and gives no result.
// A finished result sits in the output register while the next item is accepted; an item
// only waits at its last step if that register is still full.
module engine_idle_throttle_controller
    import eitc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic [RPM_W-1:0]        delta_ms,
    input  logic [RPM_W-1:0]        engine_rpm,
    input  logic signed [SIG_W-1:0] driver_throttle,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SIG_W-1:0] idle_throttle,
    output logic signed [SIG_W-1:0] engine_load
);

`include "engine_idle_throttle_controller_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FCT,
        ST_DIV,
        ST_TGT,
        ST_LOAD,
        ST_NUM,
        ST_FAST,
        ST_SLOW,
        ST_DEC,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [RPM_W-1:0]        rpm_start_reg;
    logic [RPM_W-1:0]        rpm_running_reg;
    logic signed [SIG_W-1:0] load_start_reg;
    logic [TIME_W-1:0]       warmup_reg;
    logic [STEP_W-1:0]       step_reg;

    logic [TIME_W-1:0]       elapsed_reg;
    logic [RPM_W-1:0]        prev_rpm_reg;
    logic signed [SIG_W-1:0] held_reg;

    logic [RPM_W-1:0]        delta_reg;
    logic [RPM_W-1:0]        rpm_reg;
    logic signed [SIG_W-1:0] driver_reg;
    logic [FIX_W-1:0]        fct_reg;
    logic [RPM_W-1:0]        target_reg;
    logic signed [SIG_W-1:0] load_reg;
    logic signed [PROD_W-1:0] num_reg;
    logic                    fast_reg;
    logic signed [SIG_W-1:0] res_idle_reg;

    logic                    out_valid_reg;
    logic signed [SIG_W-1:0] idle_out_reg;
    logic signed [SIG_W-1:0] load_out_reg;

    logic [TIME_W:0]          elapsed_sum;
    logic [TIME_W-1:0]        elapsed_next;
    logic                     warm_now;
    logic                     div_start;
    logic                     div_done;
    logic [DIV_STEPS-1:0]     div_quo;
    mul_op_t                  mul_op;
    mul_src_t                 mul_src;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_neg;
    logic [SIG_W:0]           load_mag;
    logic signed [SIG_W-1:0]  load_next;
    logic signed [FIX_W-1:0]  gap;
    logic signed [FIX_W-1:0]  den;
    logic                     den_neg;
    logic [RPM_W-1:0]         den_abs;
    logic                     slow;
    logic                     keep;
    logic                     more;
    logic signed [THR_W-1:0]  up_sum;
    logic signed [THR_W-1:0]  down_sum;
    logic signed [SIG_W-1:0]  held_next;
    logic                     out_free;

    assign elapsed_sum  = {1'b0, elapsed_reg} + {{(TIME_W-RPM_W+1){1'b0}}, delta_ms};
    assign elapsed_next = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];

    assign warm_now  = (warmup_reg == '0) || (elapsed_reg >= warmup_reg);
    assign div_start = (state_reg == ST_FCT) && !warm_now;

    eitc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_reg),
        .divisor  (warmup_reg),
        .done_reg (div_done),
        .quo_reg  (div_quo)
    );

    assign gap     = {1'b0, target_reg} - {1'b0, rpm_reg};
    assign den     = {1'b0, rpm_reg} - {1'b0, prev_rpm_reg};
    assign den_neg = den[FIX_W-1];
    assign den_abs = den_neg ? RPM_W'(-den) : den[RPM_W-1:0];

    always_comb
    begin
        mul_src.ramp_diff  = {1'b0, rpm_running_reg} - {1'b0, rpm_start_reg};
        mul_src.fct        = fct_reg;
        mul_src.load_start = load_start_reg;
        mul_src.gap        = gap;
        mul_src.delta      = delta_reg;
        mul_src.den_abs    = den_abs;
        case (state_reg)
            ST_TGT:  mul_op = MUL_TARGET;
            ST_LOAD: mul_op = MUL_LOAD;
            ST_NUM:  mul_op = MUL_NUM;
            ST_FAST: mul_op = MUL_FAST;
            ST_SLOW: mul_op = MUL_SLOW;
            default: mul_op = MUL_TARGET;
        endcase
    end

    eitc_mul u_mul (
        .clk      (clk),
        .op       (mul_op),
        .src      (mul_src),
        .prod_reg (prod_reg)
    );

    // load rounds toward zero
    assign prod_neg  = -prod_reg;
    assign load_mag  = prod_neg[SIG_W+16:16];
    assign load_next = prod_reg[PROD_W-1] ? SIG_W'(~load_mag + 1'b1) : prod_reg[SIG_W+15:16];

    assign slow = num_reg > prod_reg;

    always_comb
    begin
        keep = 1'b0;
        more = 1'b0;
        if (den == '0)
            more = gap > 0;
        else if (num_reg[PROD_W-1])
            more = gap > 0;
        else if (fast_reg)
            more = gap < 0;
        else if (slow)
            more = gap > 0;
        else
            keep = 1'b1;
    end

    assign up_sum   = THR_W'(held_reg) + $signed({3'b000, step_reg});
    assign down_sum = THR_W'(held_reg) - $signed({3'b000, step_reg});

    always_comb
    begin
        if (keep)
            held_next = held_reg;
        else if (more)
            held_next = (up_sum > THR_HI) ? SIG_W'(THR_HI) : SIG_W'(up_sum);
        else
            held_next = (down_sum < THR_LO) ? SIG_W'(THR_LO) : SIG_W'(down_sum);
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_start_reg   <= RPM_START_RESET;
            rpm_running_reg <= RPM_RUNNING_RESET;
            load_start_reg  <= LOAD_START_RESET;
            warmup_reg      <= WARMUP_RESET;
            step_reg        <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RPM_START:   rpm_start_reg   <= cfg_data[RPM_W-1:0];
                CFG_RPM_RUNNING: rpm_running_reg <= cfg_data[RPM_W-1:0];
                CFG_LOAD_START:  load_start_reg  <= cfg_data[SIG_W-1:0];
                CFG_WARMUP_TIME: warmup_reg      <= cfg_data[TIME_W-1:0];
                CFG_THR_STEP:    step_reg        <= cfg_data[STEP_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elapsed_reg   <= '0;
            prev_rpm_reg  <= RPM_START_RESET;
            held_reg      <= HELD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the output state loads the register itself when it is freed
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (func)
                        begin
                            elapsed_reg  <= '0;
                            prev_rpm_reg <= rpm_start_reg;
                            held_reg     <= HELD_RESET;
                        end
                        else
                        begin
                            elapsed_reg <= elapsed_next;
                            state_reg   <= ST_FCT;
                        end
                    end
                end
                ST_FCT:
                begin
                    if (warm_now)
                    begin
                        fct_reg   <= FIX_ONE;
                        state_reg <= ST_TGT;
                    end
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        fct_reg   <= {1'b0, div_quo};
                        state_reg <= ST_TGT;
                    end
                end
                ST_TGT:
                    state_reg <= ST_LOAD;
                ST_LOAD:
                begin
                    // start plus floor of the ramp part
                    target_reg <= RPM_W'({1'b0, rpm_start_reg} + prod_reg[32:16]);
                    state_reg  <= ST_NUM;
                end
                ST_NUM:
                begin
                    load_reg  <= load_next;
                    state_reg <= ST_FAST;
                end
                ST_FAST:
                begin
                    num_reg   <= den_neg ? prod_neg : prod_reg;
                    state_reg <= ST_SLOW;
                end
                ST_SLOW:
                begin
                    fast_reg  <= num_reg < prod_reg;
                    state_reg <= ST_DEC;
                end
                ST_DEC:
                begin
                    if (target_reg == '0)
                        res_idle_reg <= '0;
                    else if (delta_reg == '0)
                        res_idle_reg <= held_reg;
                    else
                    begin
                        held_reg     <= held_next;
                        prev_rpm_reg <= rpm_reg;
                        res_idle_reg <= (held_next > driver_reg) ? held_next : driver_reg;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        idle_out_reg  <= res_idle_reg;
                        load_out_reg  <= load_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !func)
        begin
            delta_reg  <= delta_ms;
            rpm_reg    <= engine_rpm;
            driver_reg <= driver_throttle;
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign idle_throttle = idle_out_reg;
    assign engine_load   = load_out_reg;

    `EITC_ASSERT_IMP(a_held_range, 1'b1, held_reg >= THR_LO && held_reg <= THR_HI)
    `EITC_ASSERT_NXT(a_busy_after_tick, in_valid && in_ready && !func, !in_ready)
    `EITC_ASSERT_IMP(a_div_done_in_wait, div_done, state_reg == ST_DIV)
    `EITC_ASSERT_IMP(a_factor_bounded, state_reg == ST_TGT, fct_reg <= FIX_ONE)

endmodule

// File: tb/engine_idle_throttle_checker.sv
`timescale 1ns / 1ps

package idle_ctrl_tb_pkg;

    typedef enum logic {
        FUNC_TICK    = 1'b0,
        FUNC_RESTART = 1'b1
    } func_code_t;

endpackage

module engine_idle_throttle_checker
    import eitc_pkg::*;
    import idle_ctrl_tb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    func,
    input  logic [RPM_W-1:0]        delta_ms,
    input  logic [RPM_W-1:0]        engine_rpm,
    input  logic signed [SIG_W-1:0] driver_throttle,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [SIG_W-1:0] idle_throttle,
    input  logic signed [SIG_W-1:0] engine_load,
    output int                      error_count,
    output int                      results_pending
);

    // keeps the log readable when something is broken everywhere
    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic [SIG_W-1:0] throttle;
        logic [SIG_W-1:0] load;
    } idle_result_t;

    idle_result_t awaited_results[$];
    idle_result_t oldest;

    logic [RPM_W-1:0]        start_rpm;
    logic [RPM_W-1:0]        running_rpm;
    logic signed [SIG_W-1:0] start_load;
    logic [TIME_W-1:0]       warmup_ms;
    logic [STEP_W-1:0]       step_size;

    logic [TIME_W-1:0]       warm_clock;
    logic [RPM_W-1:0]        last_rpm;
    int                      held_throttle;

    initial
    begin
        error_count = 0;
        results_pending = 0;
    end

    function automatic idle_result_t run_tick(logic [RPM_W-1:0] dt, logic [RPM_W-1:0] rpm,
                                              logic signed [SIG_W-1:0] driver);
        longint unsigned sum;
        longint unsigned fct;
        longint          prod;
        longint          goal;
        longint          load;
        longint          num;
        longint          den;
        longint          rpm_now;
        int              stepped;
        bit              hold;
        bit              raise;
        idle_result_t    res;

        sum = 64'(warm_clock) + 64'(dt);
        warm_clock = (sum > 64'hFFFF_FFFF) ? '1 : TIME_W'(sum);

        if (warmup_ms == '0)
            fct = 65536;
        else
        begin
            fct = (64'(warm_clock) << 16) / 64'(warmup_ms);
            if (fct > 65536)
                fct = 65536;
        end

        // ramp between the two idle targets, never negative
        prod = longint'(start_rpm) * 65536 +
               (longint'(running_rpm) - longint'(start_rpm)) * longint'(fct);
        goal = prod / 65536;

        prod = longint'(start_load) * (65536 - longint'(fct));
        load = prod / 65536;
        res.load = SIG_W'(load);

        if (goal == 0)
        begin
            res.throttle = '0;
            return res;
        end
        if (dt == '0)
        begin
            res.throttle = SIG_W'(held_throttle);
            return res;
        end

        rpm_now = longint'(rpm);
        den = rpm_now - longint'(last_rpm);
        num = (goal - rpm_now) * longint'(dt);
        hold = 1'b0;
        if (den == 0)
            raise = rpm_now < goal;
        else
        begin
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            if (num < 0)
                raise = rpm_now < goal;
            else if (num < FAST_MS * den)
                raise = rpm_now > goal;
            else if (num > SLOW_MS * den)
                raise = rpm_now < goal;
            else
            begin
                hold = 1'b1;
                raise = 1'b0;
            end
        end

        if (!hold)
        begin
            if (raise)
            begin
                stepped = held_throttle + int'(step_size);
                if (stepped > SIGNAL_MAX / 2)
                    stepped = SIGNAL_MAX / 2;
            end
            else
            begin
                stepped = held_throttle - int'(step_size);
                if (stepped < SIGNAL_NEUTRAL)
                    stepped = SIGNAL_NEUTRAL;
            end
            held_throttle = stepped;
        end

        last_rpm = rpm;
        res.throttle = SIG_W'((held_throttle > int'(driver)) ? held_throttle : int'(driver));
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start_rpm = RPM_START_RESET;
            running_rpm = RPM_RUNNING_RESET;
            start_load = LOAD_START_RESET;
            warmup_ms = WARMUP_RESET;
            step_size = STEP_RESET;
            warm_clock = '0;
            last_rpm = RPM_START_RESET;
            held_throttle = SIGNAL_MAX / 4;
            awaited_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_RPM_START:   start_rpm = RPM_W'(cfg_data);
                    CFG_RPM_RUNNING: running_rpm = RPM_W'(cfg_data);
                    CFG_LOAD_START:  start_load = SIG_W'(cfg_data);
                    CFG_WARMUP_TIME: warmup_ms = cfg_data;
                    CFG_THR_STEP:    step_size = STEP_W'(cfg_data);
                    default:         ;
                endcase
            end

            // results leave before a new item is taken in the same cycle
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $error("unexpected item: idle_throttle %0d, engine_load %0d",
                               idle_throttle, engine_load);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (idle_throttle !== oldest.throttle)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $error("idle_throttle: expected %0d, actual %0d",
                                   $signed(oldest.throttle), idle_throttle);
                    end
                    if (engine_load !== oldest.load)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $error("engine_load: expected %0d, actual %0d",
                                   $signed(oldest.load), engine_load);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (func == FUNC_RESTART)
                begin
                    warm_clock = '0;
                    last_rpm = start_rpm;
                    held_throttle = SIGNAL_MAX / 4;
                end
                else
                    awaited_results.push_back(run_tick(delta_ms, engine_rpm, driver_throttle));
            end
        end
        results_pending = awaited_results.size();
    end

endmodule

// File: tb/tb_engine_idle_throttle_controller.sv
`timescale 1ns / 1ps

module tb_engine_idle_throttle_controller;
    import eitc_pkg::*;
    import idle_ctrl_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 190;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    func = 1'b0;
    logic [RPM_W-1:0]        delta_ms = '0;
    logic [RPM_W-1:0]        engine_rpm = '0;
    logic signed [SIG_W-1:0] driver_throttle = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [SIG_W-1:0] idle_throttle;
    logic signed [SIG_W-1:0] engine_load;

    int          fault_count;
    int          pending_count;
    int unsigned cycle_count = 0;
    bit          steady_flow = 1'b0;
    int          cfg_start = 1100;
    int          cfg_running = 900;
    int          walk_rpm = 1100;

    engine_idle_throttle_controller DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .delta_ms        (delta_ms),
        .engine_rpm      (engine_rpm),
        .driver_throttle (driver_throttle),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .idle_throttle   (idle_throttle),
        .engine_load     (engine_load)
    );

    engine_idle_throttle_checker u_throttle_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .delta_ms        (delta_ms),
        .engine_rpm      (engine_rpm),
        .driver_throttle (driver_throttle),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .idle_throttle   (idle_throttle),
        .engine_load     (engine_load),
        .error_count     (fault_count),
        .results_pending (pending_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // mostly back to back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (steady_flow || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else
            begin
                out_ready = 1'b1;
                if ($urandom_range(99) < 25)
                    stall = pick_gap();
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(func_code_t op, logic [RPM_W-1:0] dt, logic [RPM_W-1:0] rpm,
                             logic signed [SIG_W-1:0] driver);
        int gap;
        func = op;
        delta_ms = dt;
        engine_rpm = rpm;
        driver_throttle = driver;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // restart items give no result, so allow for work still in flight
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_settings(int start, int running, int load, logic [TIME_W-1:0] warm,
                                 int step);
        drain_results();
        write_reg(CFG_RPM_START, CFG_W'(start));
        write_reg(CFG_RPM_RUNNING, CFG_W'(running));
        write_reg(CFG_LOAD_START, CFG_W'(load));
        write_reg(CFG_WARMUP_TIME, warm);
        write_reg(CFG_THR_STEP, CFG_W'(step));
        cfg_start = start;
        cfg_running = running;
        walk_rpm = start;
    endtask

    task automatic random_item();
        int                      roll;
        int                      goal;
        int                      next;
        logic signed [SIG_W-1:0] driver;
        roll = $urandom_range(99);
        driver = SIG_W'(int'($urandom_range(2000)) - 1000);
        if (roll < 3)
        begin
            send_item(FUNC_RESTART, RPM_W'($urandom), RPM_W'($urandom), driver);
            walk_rpm = cfg_start;
        end
        else if (roll < 12)
            send_item(FUNC_TICK, RPM_W'($urandom), RPM_W'($urandom), driver);
        else if (roll < 16)
            send_item(FUNC_TICK, '0, RPM_W'(walk_rpm), driver);
        else
        begin
            // rpm creeping toward a target, so the hold band gets hit too
            goal = ($urandom_range(3) == 0) ? cfg_start : cfg_running;
            next = walk_rpm + int'($urandom_range(6)) - 3;
            if (goal > walk_rpm)
                next = next + int'($urandom_range(12));
            else if (goal < walk_rpm)
                next = next - int'($urandom_range(12));
            if ($urandom_range(19) == 0)
                next = goal + int'($urandom_range(400)) - 200;
            if (next < 0)
                next = 0;
            if (next > 65535)
                next = 65535;
            walk_rpm = next;
            if ($urandom_range(3) != 0)
                driver = SIG_W'(int'($urandom_range(1200)) - 1000);
            send_item(FUNC_TICK, RPM_W'($urandom_range(40, 1)), RPM_W'(walk_rpm), driver);
        end
    endtask

    task automatic run_phase(int count, bit pause_midway);
        for (int n = 0; n < count; n++)
        begin
            if (pause_midway && n == count / 2)
                drain_results();
            random_item();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // settings out of reset: 1100 -> 900 rpm over 10 ms
        send_item(FUNC_TICK, 0, 1100, 0);
        send_item(FUNC_TICK, 2, 1100, -1000);
        send_item(FUNC_TICK, 3, 1150, 1000);
        send_item(FUNC_TICK, 1, 1149, 0);
        send_item(FUNC_TICK, 100, 1000, 0);
        send_item(FUNC_TICK, 1, 901, 0);
        send_item(FUNC_TICK, 16'hFFFF, 16'hFFFF, 1000);
        send_item(FUNC_TICK, 16'hFFFF, 0, -1000);
        send_item(FUNC_RESTART, 16'hFFFF, 16'hFFFF, -1000);
        send_item(FUNC_TICK, 1, 1100, -1);

        // zero target wins over zero delta
        load_settings(0, 0, -1000, 10, 1000);
        send_item(FUNC_TICK, 5, 50, 300);
        send_item(FUNC_TICK, 0, 0, 1000);

        // big step runs into both throttle clamps
        load_settings(1100, 900, 1000, 0, 1000);
        send_item(FUNC_TICK, 1, 2000, -1000);
        send_item(FUNC_TICK, 1, 100, -1000);
        send_item(FUNC_TICK, 1, 150, -1000);
        send_item(FUNC_RESTART, 0, 0, 0);
        send_item(FUNC_TICK, 0, 700, 0);

        load_settings(1100, 900, 5, 10, 5);
        send_item(FUNC_RESTART, 0, 1100, 0);
        run_phase(PHASE_ITEMS, 1'b0);

        load_settings(65535, 0, -1000, 32'hFFFF_FFFF, 1000);
        send_item(FUNC_RESTART, 0, 0, 0);
        run_phase(PHASE_ITEMS, 1'b0);

        steady_flow = 1'b1;
        load_settings(0, 65535, 1000, 0, 0);
        run_phase(PHASE_ITEMS, 1'b0);
        steady_flow = 1'b0;

        load_settings(int'($urandom_range(3000, 500)), int'($urandom_range(3000, 500)),
                      int'($urandom_range(2000)) - 1000, $urandom_range(3000, 1),
                      int'($urandom_range(40, 1)));
        send_item(FUNC_RESTART, 0, 0, 0);
        run_phase(PHASE_ITEMS, 1'b1);

        // running target of zero once warm
        load_settings(800, 0, 300, 200, 20);
        send_item(FUNC_RESTART, 0, 0, 0);
        run_phase(PHASE_ITEMS, 1'b0);

        load_settings(int'($urandom_range(65535)), int'($urandom_range(65535)),
                      int'($urandom_range(2000)) - 1000, $urandom_range(100000, 1),
                      int'($urandom_range(1000)));
        run_phase(PHASE_ITEMS, 1'b0);

        drain_results();
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
